### hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WIN_MAX   = 64;
	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int DATA_W    = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     start_req;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_POP,
		ST_PUSH,
		ST_HRD,
		ST_OUT
	} state_t;

endpackage

### hdl/swm_if.sv
// ----------------------------------------------------------------------------
// swm_sample_if / swm_result_if
// Valid/ready channels for samples and window maxima.
// ----------------------------------------------------------------------------
interface swm_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [swm_pkg::DATA_W-1:0] sample;
	logic                              start_req;
	modport source(output valid, output sample, output start_req, input ready);
	modport sink(input valid, input sample, input start_req, output ready);
endinterface

interface swm_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [swm_pkg::DATA_W-1:0] window_max;
	modport source(output valid, output window_max, input ready);
	modport sink(input valid, input window_max, output ready);
endinterface

### hdl/swm_front.sv
// ----------------------------------------------------------------------------
// swm_front
// Accepts sample transfers and queues them for the back end.
// ----------------------------------------------------------------------------
module swm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	swm_sample_if.sink           sample_ch,
	output logic                 deq_valid,
	input  logic                 deq_ready,
	output swm_pkg::item_t       deq_item
);

	swm_pkg::item_t                mem_q [swm_pkg::FIFO_DEPTH];
	logic [swm_pkg::FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [swm_pkg::FIFO_PTR_W:0]   cnt_q;
	logic                           push, pop;

	assign sample_ch.ready = (cnt_q != 3'(swm_pkg::FIFO_DEPTH));
	assign push      = sample_ch.valid && sample_ch.ready;
	assign deq_valid = (cnt_q != '0);
	assign pop       = deq_valid && deq_ready;
	assign deq_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{sample: sample_ch.sample, start_req: sample_ch.start_req};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

### hdl/swm_back.sv
// ----------------------------------------------------------------------------
// swm_back
// Sample ring and monotonic queue in memories, stepped by a sequencer.
// ----------------------------------------------------------------------------
module swm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [swm_pkg::CNT_W-1:0] cfg_wdata,
	input  logic                  deq_valid,
	output logic                  deq_ready,
	input  swm_pkg::item_t        deq_item,
	swm_result_if.source          result_ch
);

	logic [swm_pkg::DATA_W-1:0] rmem [swm_pkg::WIN_MAX];
	logic [swm_pkg::DATA_W-1:0] qmem [swm_pkg::WIN_MAX];

	swm_pkg::state_t             state_q, state_n;
	swm_pkg::item_t              cur_q;
	logic [swm_pkg::CNT_W-1:0]   wlen_q, k, fill_q, len_q, len_n;
	logic [swm_pkg::IDX_W-1:0]   wp_q, h_q, h_n;
	logic [swm_pkg::IDX_W-1:0]   r_addr, q_addr, q_waddr;
	logic                        q_we, r_we, evict, pop_tail, load_out;
	logic signed [swm_pkg::DATA_W-1:0] q_rd_q;
	logic [swm_pkg::DATA_W-1:0]  r_rd_q;
	logic                        out_valid_q;
	logic signed [swm_pkg::DATA_W-1:0] out_data_q;

	assign k = (wlen_q > 7'(swm_pkg::WIN_MAX)) ? 7'(swm_pkg::WIN_MAX) : wlen_q;
	assign evict    = (fill_q >= k) && (len_q != '0) && (q_rd_q == r_rd_q);
	assign h_n      = h_q + {5'b0, evict};
	assign len_n    = len_q - {6'b0, evict};
	assign pop_tail = (len_q != '0) && (cur_q.sample > q_rd_q);
	assign load_out = (state_q == swm_pkg::ST_OUT) && (fill_q >= k)
		&& (!out_valid_q || result_ch.ready);

	assign result_ch.valid      = out_valid_q;
	assign result_ch.window_max = out_data_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			swm_pkg::ST_IDLE: if (deq_valid && k != '0) state_n = swm_pkg::ST_CMP;
			swm_pkg::ST_CMP:  state_n = swm_pkg::ST_POP;
			swm_pkg::ST_POP:  if (!pop_tail) state_n = swm_pkg::ST_PUSH;
			swm_pkg::ST_PUSH: state_n = swm_pkg::ST_HRD;
			swm_pkg::ST_HRD:  state_n = swm_pkg::ST_OUT;
			swm_pkg::ST_OUT:  if (load_out || fill_q < k) state_n = swm_pkg::ST_IDLE;
			default:          state_n = swm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		deq_ready = 1'b0;
		r_addr    = wp_q - k[swm_pkg::IDX_W-1:0];
		q_addr    = h_q;
		q_we      = 1'b0;
		r_we      = 1'b0;
		q_waddr   = h_q + len_q[swm_pkg::IDX_W-1:0];
		case (state_q)
			swm_pkg::ST_IDLE: begin
				deq_ready = 1'b1;
				if (deq_item.start_req) begin
					r_addr = '0 - k[swm_pkg::IDX_W-1:0];
					q_addr = '0;
				end
			end
			swm_pkg::ST_CMP:  q_addr = h_n + len_n[swm_pkg::IDX_W-1:0] - 6'd1;
			swm_pkg::ST_POP:  q_addr = h_q + len_q[swm_pkg::IDX_W-1:0] - 6'd2;
			swm_pkg::ST_PUSH: begin
				q_we = !len_q[swm_pkg::CNT_W-1];
				r_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) qmem[q_waddr] <= cur_q.sample;
		if (r_we) rmem[wp_q] <= cur_q.sample;
		q_rd_q <= qmem[q_addr];
		r_rd_q <= rmem[r_addr];
		if (state_q == swm_pkg::ST_IDLE && deq_valid) cur_q <= deq_item;
		if (load_out) out_data_q <= q_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swm_pkg::ST_IDLE;
			wlen_q      <= 7'd1;
			wp_q        <= '0;
			h_q         <= '0;
			len_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ch.ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				wlen_q <= cfg_wdata;
				wp_q   <= '0;
				h_q    <= '0;
				len_q  <= '0;
				fill_q <= '0;
			end else begin
				case (state_q)
					swm_pkg::ST_IDLE: begin
						if (deq_valid && deq_item.start_req) begin
							wp_q   <= '0;
							h_q    <= '0;
							len_q  <= '0;
							fill_q <= '0;
						end
					end
					swm_pkg::ST_CMP: begin
						h_q   <= h_n;
						len_q <= len_n;
					end
					swm_pkg::ST_POP: if (pop_tail) len_q <= len_q - 7'd1;
					swm_pkg::ST_PUSH: begin
						if (!len_q[swm_pkg::CNT_W-1]) len_q <= len_q + 7'd1;
						wp_q <= wp_q + 6'd1;
						if (fill_q < k) fill_q <= fill_q + 7'd1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

### hdl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Maximum of the last window_len signed samples of a stream.
// ----------------------------------------------------------------------------
// Samples arrive on sample_ch (valid/ready); a transfer with start_req set
// begins a new sequence. Once window_len samples of the sequence have been
// taken, each further sample yields one transfer on result_ch carrying the
// maximum of the last window_len samples; earlier samples yield nothing.
// cfg_we/cfg_wdata write window_len (1..64, larger saturates to 64) and
// restart the sequence; write only while idle. window_len 0 drops samples.
// A four-entry queue takes samples while the back end works. The back end
// takes one sample at a time and steps through IDLE, CMP, POP (repeated
// for each queue tail popped), PUSH, HRD and OUT, where it waits for any
// previous result still pending on result_ch to be taken; the sequencer
// issues one queue memory read per step. Each sample is popped at most once.
// Reset clears the sequence and sets window_len to 1. A stalled result_ch
// holds its result; the back end then waits, and the input queue fills
// and drops ready.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [swm_pkg::CNT_W-1:0] cfg_wdata,
	swm_sample_if.sink                sample_ch,
	swm_result_if.source              result_ch
);

	logic           deq_valid, deq_ready;
	swm_pkg::item_t deq_item;

	swm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item)
	);

	swm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item),
		.result_ch (result_ch)
	);

endmodule

### tb/sliding_window_maximum_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb
// Self-checking testbench for the sliding window maximum block.
// ----------------------------------------------------------------------------
// A model of the ring and the monotonic queue predicts each window maximum
// the block should yield. Results are checked in order against it.
// Directed cases cover field extremes, ties and restarts. Random phases
// sweep window_len, including zero and values past the saturation point.
// Both channels idle at random, and one long receiver hold-off fills the
// input queue so that the block drops ready.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;

	localparam int SETTLE_CYCLES = 500;
	localparam int EXP_DEPTH = 2048;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [swm_pkg::CNT_W-1:0] cfg_wdata;

	swm_sample_if sample_ch ();
	swm_result_if result_ch ();

	sliding_window_maximum u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// predicted state
	logic signed [swm_pkg::DATA_W-1:0] win_ring [swm_pkg::WIN_MAX];
	logic signed [swm_pkg::DATA_W-1:0] cand_q [swm_pkg::WIN_MAX];
	int wr_pos;
	int cand_len;
	int fill_cnt;
	int win_len;

	logic signed [swm_pkg::DATA_W-1:0] exp_max [EXP_DEPTH];
	int exp_wr;
	int exp_rd;
	int errors;
	int burst_left;
	int hold_cycles;
	int rx_mode_left;
	int rx_mode;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#20_000_000;
		$display("** sliding_window_maximum: FAILED **");
		$finish;
	end

	function automatic void clear_window();
		wr_pos = 0;
		cand_len = 0;
		fill_cnt = 0;
	endfunction

	function automatic void predict_max(input logic signed [swm_pkg::DATA_W-1:0] s,
		input logic st);
		int k;
		int idx;
		if (st)
			clear_window();
		k = (win_len > swm_pkg::WIN_MAX) ? swm_pkg::WIN_MAX : win_len;
		if (k == 0)
			return;
		if (fill_cnt >= k) begin
			idx = (wr_pos + swm_pkg::WIN_MAX - k) % swm_pkg::WIN_MAX;
			if (cand_len > 0 && cand_q[0] == win_ring[idx]) begin
				for (int i = 0; i < cand_len - 1; i++)
					cand_q[i] = cand_q[i+1];
				cand_len--;
			end
		end
		while (cand_len > 0 && s > cand_q[cand_len-1])
			cand_len--;
		if (cand_len < swm_pkg::WIN_MAX) begin
			cand_q[cand_len] = s;
			cand_len++;
		end
		win_ring[wr_pos] = s;
		wr_pos = (wr_pos + 1) % swm_pkg::WIN_MAX;
		if (fill_cnt < k)
			fill_cnt++;
		if (fill_cnt >= k) begin
			exp_max[exp_wr % EXP_DEPTH] = cand_q[0];
			exp_wr++;
		end
	endfunction

	// receiver: random stall pattern, plus a counted hold-off
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(10, 80);
		end else begin
			rx_mode_left--;
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_ch.ready <= 1'b0;
		end else if (rx_mode == 0) begin
			result_ch.ready <= 1'b1;
		end else if (rx_mode == 1) begin
			result_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			result_ch.ready <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		logic signed [swm_pkg::DATA_W-1:0] want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time,
					result_ch.window_max);
				errors++;
			end else begin
				want = exp_max[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (result_ch.window_max !== want) begin
					$display("%0t: window_max mismatch, expected %0d, actual %0d", $time,
						want, result_ch.window_max);
					errors++;
				end
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_sample(input logic signed [swm_pkg::DATA_W-1:0] s, input logic st);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.start_req <= st;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predict_max(s, st);
		@(negedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (exp_wr != exp_rd)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input int len);
		cfg_we <= 1'b1;
		cfg_wdata <= len[swm_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		win_len = len;
		clear_window();
	endtask

	function automatic logic signed [swm_pkg::DATA_W-1:0] rand_sample();
		case ($urandom_range(0, 4))
			0: rand_sample = $signed($urandom_range(0, 8)) - 4;
			1: rand_sample = ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
			default: rand_sample = $urandom;
		endcase
	endfunction

	task automatic test_field_extremes();
		send_sample(32'sh7fffffff, 1'b1);
		send_sample(32'sh80000000, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(32'sh55555555, 1'b0);
		send_sample(32'shaaaaaaaa, 1'b1);
		drain();
	endtask

	task automatic test_ties_and_restart();
		write_window(3);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(9, 1'b0);
		send_sample(4, 1'b0);
		send_sample(3, 1'b0);
		send_sample(2, 1'b0);
		send_sample(-7, 1'b1);
		send_sample(8, 1'b0);
		send_sample(1, 1'b1);
		send_sample(2, 1'b0);
		send_sample(3, 1'b0);
		send_sample(4, 1'b0);
		drain();
	endtask

	task automatic test_zero_window();
		write_window(0);
		send_sample(12, 1'b0);
		send_sample(-3, 1'b1);
		send_sample(40, 1'b0);
		drain();
	endtask

	task automatic test_random_windows();
		int lens [12] = '{1, 2, 3, 5, 8, 17, 33, 64, 100, 127, 0, 64};
		int n;
		foreach (lens[i]) begin
			write_window(lens[i]);
			n = (lens[i] >= 33) ? 120 : 80;
			for (int j = 0; j < n; j++)
				send_sample(rand_sample(), ($urandom_range(0, 60) == 0));
			drain();
		end
	endtask

	task automatic test_backpressure();
		write_window(4);
		hold_cycles = 400;
		for (int j = 0; j < 40; j++)
			send_sample(rand_sample(), 1'b0);
		drain();
	endtask

	initial begin
		errors = 0;
		exp_wr = 0;
		exp_rd = 0;
		burst_left = 0;
		hold_cycles = 0;
		rx_mode_left = 0;
		rx_mode = 0;
		win_len = 1;
		clear_window();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.start_req = 1'b0;
		result_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_field_extremes();
		test_ties_and_restart();
		test_zero_window();
		test_backpressure();
		test_random_windows();
		if (errors == 0)
			$display("** sliding_window_maximum: PASSED **");
		else
			$display("** sliding_window_maximum: FAILED **");
		$finish;
	end

endmodule
